// ===== hdl/tcrs_pkg.sv =====
// Shared types, widths and constant tables for the traffic count road selector.
// No dependencies; every other file in hdl/ refers to this package by scope.
`default_nettype none

package tcrs_pkg;

    localparam int SENSOR_COUNT     = 8;
    localparam int CHANNEL_BITS     = $clog2(SENSOR_COUNT);
    localparam int SAMPLE_BITS      = 10;
    localparam int THRESH_BITS      = 10;
    localparam int COUNTER_BITS     = 16;
    localparam int BALANCE_BITS     = 16;
    localparam int ROAD_COUNT       = 4;
    localparam int ROAD_BITS        = $clog2(ROAD_COUNT);
    localparam int LAMP_BITS        = 8;
    localparam int CFG_INDEX_BITS   = 4;
    localparam int CFG_DATA_BITS    = THRESH_BITS;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CHANNEL_BITS-1:0]       channel_t;
    typedef logic [SAMPLE_BITS-1:0]        sample_t;
    typedef logic [THRESH_BITS-1:0]        thresh_t;
    typedef logic [COUNTER_BITS-1:0]       counter_t;
    typedef logic signed [BALANCE_BITS-1:0] balance_t;
    typedef logic [ROAD_BITS-1:0]          road_t;
    typedef logic [LAMP_BITS-1:0]          lamp_t;
    typedef logic [CFG_INDEX_BITS-1:0]     cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]      cfg_data_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_ARRIVE,
        ACT_DEPART
    } action_t;

    typedef struct packed {
        channel_t channel;
        action_t  action;
    } entry_t;

    localparam road_t ROAD_ONE   = 2'd0;
    localparam road_t ROAD_TWO   = 2'd1;
    localparam road_t ROAD_THREE = 2'd2;
    localparam road_t ROAD_FOUR  = 2'd3;

    function automatic thresh_t thresh_reset(input channel_t ch);
        thresh_t th;
        unique case (ch)
            3'd0:    th = 10'd400;
            3'd1:    th = 10'd613;
            3'd2:    th = 10'd480;
            3'd3:    th = 10'd562;
            3'd4:    th = 10'd572;
            3'd5:    th = 10'd204;
            3'd6:    th = 10'd523;
            default: th = 10'd163;
        endcase
        return th;
    endfunction

    function automatic lamp_t lamp_for(input road_t road);
        lamp_t lamp;
        unique case (road)
            ROAD_ONE:   lamp = 8'b10101001;
            ROAD_TWO:   lamp = 8'b10100110;
            ROAD_THREE: lamp = 8'b10011010;
            default:    lamp = 8'b01101010;
        endcase
        return lamp;
    endfunction

    function automatic channel_t pair_plus(input road_t road);
        channel_t ch;
        unique case (road)
            ROAD_ONE:   ch = 3'd6;
            ROAD_TWO:   ch = 3'd2;
            ROAD_THREE: ch = 3'd7;
            default:    ch = 3'd1;
        endcase
        return ch;
    endfunction

    function automatic channel_t pair_minus(input road_t road);
        channel_t ch;
        unique case (road)
            ROAD_ONE:   ch = 3'd0;
            ROAD_TWO:   ch = 3'd3;
            ROAD_THREE: ch = 3'd5;
            default:    ch = 3'd4;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tcrs_front.sv =====
// Front end: threshold registers and sample classification.
// Depends on tcrs_pkg.
`default_nettype none

module tcrs_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire tcrs_pkg::cfg_index_t cfg_index,
    input  wire tcrs_pkg::cfg_data_t  cfg_data,
    input  wire tcrs_pkg::channel_t   sensor_channel,
    input  wire tcrs_pkg::sample_t    sensor_sample,
    output tcrs_pkg::entry_t          entry
);

    tcrs_pkg::thresh_t thresh_reg [tcrs_pkg::SENSOR_COUNT];
    tcrs_pkg::thresh_t thresh_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tcrs_pkg::SENSOR_COUNT; i++)
            begin
                thresh_reg[i] <= tcrs_pkg::thresh_reset(tcrs_pkg::channel_t'(i));
            end
        end
        else if (cfg_we && (cfg_index < tcrs_pkg::cfg_index_t'(tcrs_pkg::SENSOR_COUNT)))
        begin
            thresh_reg[cfg_index[tcrs_pkg::CHANNEL_BITS-1:0]] <=
                cfg_data[tcrs_pkg::THRESH_BITS-1:0];
        end
    end

    assign thresh_sel = thresh_reg[sensor_channel];

    always_comb
    begin
        entry.channel = sensor_channel;
        priority if (sensor_sample < thresh_sel)
        begin
            entry.action = tcrs_pkg::ACT_ARRIVE;
        end
        else if (sensor_sample > thresh_sel)
        begin
            entry.action = tcrs_pkg::ACT_DEPART;
        end
        else
        begin
            entry.action = tcrs_pkg::ACT_NONE;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tcrs_queue.sv =====
// Short FIFO of classified beats between the front end and the back end.
// Depends on tcrs_pkg.
`default_nettype none

module tcrs_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire tcrs_pkg::entry_t push_entry,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output tcrs_pkg::entry_t      pop_entry
);

    tcrs_pkg::entry_t entry_reg [tcrs_pkg::QUEUE_DEPTH];
    logic [tcrs_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_reg;
    logic [tcrs_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_reg;
    logic [tcrs_pkg::QUEUE_COUNT_BITS-1:0] count_reg;
    logic [tcrs_pkg::QUEUE_COUNT_BITS-1:0] count_next;
    logic push;
    logic pop;

    assign push_ready = count_reg != tcrs_pkg::QUEUE_COUNT_BITS'(tcrs_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tcrs_pkg::QUEUE_COUNT_BITS'(tcrs_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not grow the queue");
`endif

endmodule

`default_nettype wire

// ===== hdl/tcrs_back.sv =====
// Back end: presence flags, pass counters, road balances and road selection.
// Depends on tcrs_pkg; fed from tcrs_queue.
`default_nettype none

module tcrs_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    input  wire tcrs_pkg::entry_t pop_entry,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output tcrs_pkg::road_t       chosen_road,
    output tcrs_pkg::lamp_t       lamp_pattern,
    output tcrs_pkg::balance_t    road_one_balance,
    output tcrs_pkg::balance_t    road_two_balance,
    output tcrs_pkg::balance_t    road_three_balance,
    output tcrs_pkg::balance_t    road_four_balance
);

    logic [tcrs_pkg::SENSOR_COUNT-1:0] flag_reg;
    tcrs_pkg::counter_t counter_reg [tcrs_pkg::SENSOR_COUNT];
    tcrs_pkg::balance_t balance_reg [tcrs_pkg::ROAD_COUNT];
    logic pending_reg;
    logic pending_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic capture;
    logic take;
    tcrs_pkg::road_t best_low;
    tcrs_pkg::road_t best_high;
    tcrs_pkg::road_t best_road;

    assign capture   = pending_reg && (!out_valid_reg || result_ready);
    assign pop_ready = !pending_reg || capture;
    assign take      = pop_valid && pop_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (take)
        begin
            pending_next = 1'b1;
        end
        else if (capture)
        begin
            pending_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // update per-channel state from the popped beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= '0;
            for (int i = 0; i < tcrs_pkg::SENSOR_COUNT; i++)
            begin
                counter_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            unique case (pop_entry.action)
                tcrs_pkg::ACT_ARRIVE:
                begin
                    if (!flag_reg[pop_entry.channel])
                    begin
                        flag_reg[pop_entry.channel]    <= 1'b1;
                        counter_reg[pop_entry.channel] <=
                            counter_reg[pop_entry.channel] + 1'b1;
                    end
                end
                tcrs_pkg::ACT_DEPART:
                begin
                    flag_reg[pop_entry.channel] <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture balances from counters that reflect the pending beat
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int r = 0; r < tcrs_pkg::ROAD_COUNT; r++)
            begin
                balance_reg[r] <= tcrs_pkg::balance_t'(
                    counter_reg[tcrs_pkg::pair_plus(tcrs_pkg::road_t'(r))] -
                    counter_reg[tcrs_pkg::pair_minus(tcrs_pkg::road_t'(r))]);
            end
        end
    end

    // first greatest wins: lower road keeps ties at each level
    always_comb
    begin
        best_low  = (balance_reg[1] > balance_reg[0]) ? tcrs_pkg::ROAD_TWO
                                                      : tcrs_pkg::ROAD_ONE;
        best_high = (balance_reg[3] > balance_reg[2]) ? tcrs_pkg::ROAD_FOUR
                                                      : tcrs_pkg::ROAD_THREE;
        best_road = (balance_reg[best_high] > balance_reg[best_low]) ? best_high
                                                                     : best_low;
    end

    assign result_valid       = out_valid_reg;
    assign chosen_road        = best_road;
    assign lamp_pattern       = tcrs_pkg::lamp_for(best_road);
    assign road_one_balance   = balance_reg[0];
    assign road_two_balance   = balance_reg[1];
    assign road_three_balance = balance_reg[2];
    assign road_four_balance  = balance_reg[3];

`ifndef ASSERT_OFF
    a_depart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (pop_entry.action == tcrs_pkg::ACT_DEPART))
        |=> !flag_reg[$past(pop_entry.channel)])
        else $error("departure left the presence flag set");

    a_arrive_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (pop_entry.action == tcrs_pkg::ACT_ARRIVE) && !flag_reg[pop_entry.channel])
        |=> (counter_reg[$past(pop_entry.channel)] ==
             tcrs_pkg::counter_t'($past(counter_reg[pop_entry.channel]) + 1'b1)))
        else $error("new arrival did not count one pass");

    a_best_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((balance_reg[best_road] >= balance_reg[0]) &&
                           (balance_reg[best_road] >= balance_reg[1]) &&
                           (balance_reg[best_road] >= balance_reg[2]) &&
                           (balance_reg[best_road] >= balance_reg[3])))
        else $error("chosen road does not hold the greatest balance");
`endif

endmodule

`default_nettype wire

// ===== hdl/traffic_count_road_selector.sv =====
// Top level of the traffic count road selector: front end, queue and back end.
// A beat passes the queue, the counter update on pop, then the balance capture.
// Throughput: one sample beat per cycle unless result_ready stalls the back end.
// The two-entry queue lets the front keep taking beats while a result waits.
// Reset clears presence flags, pass counters and the queue, and loads default thresholds.
// Depends on tcrs_pkg, tcrs_front, tcrs_queue and tcrs_back.
`default_nettype none

module traffic_count_road_selector (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire tcrs_pkg::cfg_index_t cfg_index,
    input  wire tcrs_pkg::cfg_data_t  cfg_data,
    input  wire logic                 sensor_valid,
    output logic                      sensor_ready,
    input  wire tcrs_pkg::channel_t   sensor_channel,
    input  wire tcrs_pkg::sample_t    sensor_sample,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output tcrs_pkg::road_t           chosen_road,
    output tcrs_pkg::lamp_t           lamp_pattern,
    output tcrs_pkg::balance_t        road_one_balance,
    output tcrs_pkg::balance_t        road_two_balance,
    output tcrs_pkg::balance_t        road_three_balance,
    output tcrs_pkg::balance_t        road_four_balance
);

    tcrs_pkg::entry_t push_entry;
    tcrs_pkg::entry_t pop_entry;
    logic             pop_valid;
    logic             pop_ready;

    tcrs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sensor_channel (sensor_channel),
        .sensor_sample  (sensor_sample),
        .entry          (push_entry)
    );

    tcrs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (sensor_valid),
        .push_ready (sensor_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    tcrs_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .pop_valid          (pop_valid),
        .pop_ready          (pop_ready),
        .pop_entry          (pop_entry),
        .result_valid       (result_valid),
        .result_ready       (result_ready),
        .chosen_road        (chosen_road),
        .lamp_pattern       (lamp_pattern),
        .road_one_balance   (road_one_balance),
        .road_two_balance   (road_two_balance),
        .road_three_balance (road_three_balance),
        .road_four_balance  (road_four_balance)
    );

endmodule

`default_nettype wire

// ===== dv/traffic_count_road_selector_tb.sv =====
// Self-checking testbench for traffic_count_road_selector: drives sensor sample beats,
// writes thresholds, and checks every result beat against directed expected values or an in-bench predictor.
// Depends on tcrs_pkg and the traffic_count_road_selector top level only.
module traffic_count_road_selector_tb;
    import tcrs_pkg::*;

    typedef struct packed {
        road_t    road;
        lamp_t    lamp;
        balance_t one;
        balance_t two;
        balance_t three;
        balance_t four;
    } readout_t;

    typedef struct packed {
        channel_t ch;
        sample_t  smp;
        logic     typed;
        readout_t want;
    } step_row_t;

    localparam thresh_t THRESH_DEFAULT [SENSOR_COUNT] =
        '{10'd400, 10'd613, 10'd480, 10'd562, 10'd572, 10'd204, 10'd523, 10'd163};
    localparam lamp_t LAMP_OF_ROAD [ROAD_COUNT] = '{8'hA9, 8'hA6, 8'h9A, 8'h6A};
    localparam int ADDEND_CH [ROAD_COUNT] = '{6, 2, 7, 1};
    localparam int SUBTRAHEND_CH [ROAD_COUNT] = '{0, 3, 5, 4};

    localparam cfg_index_t THRESH_REG_BASE    = 4'd0;
    localparam cfg_index_t UNMAPPED_REG_FIRST = 4'd8;
    localparam cfg_index_t UNMAPPED_REG_LAST  = 4'd15;
    localparam cfg_data_t  CFG_DATA_MIN       = '0;
    localparam cfg_data_t  CFG_DATA_MAX       = '1;

    localparam int       SAMPLE_MAX         = (1 << SAMPLE_BITS) - 1;
    localparam int       IDLE_MAX           = 18;
    localparam channel_t WRAP_CHANNEL       = 3'd6;
    localparam int       WRAP_PASSES        = 80;
    localparam int       RANDOM_PHASE_BEATS = 392;
    localparam int       CHUNK_BEATS        = 49;
    localparam int       MISS_PRINT_CAP     = 40;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cfg_we         = 1'b0;
    cfg_index_t cfg_index      = '0;
    cfg_data_t  cfg_data       = '0;
    logic       sensor_valid   = 1'b0;
    logic       sensor_ready;
    channel_t   sensor_channel = '0;
    sample_t    sensor_sample  = '0;
    logic       result_valid;
    logic       result_ready   = 1'b0;
    road_t      chosen_road;
    lamp_t      lamp_pattern;
    balance_t   road_one_balance;
    balance_t   road_two_balance;
    balance_t   road_three_balance;
    balance_t   road_four_balance;

    thresh_t  thresholds [SENSOR_COUNT];
    logic     occupied [SENSOR_COUNT];
    counter_t passes [SENSOR_COUNT];
    readout_t pending_readouts [$];

    int gap_max    = IDLE_MAX;
    int stall_max  = IDLE_MAX;
    int ready_hold = 0;
    int miss_count = 0;

    traffic_count_road_selector uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .sensor_valid       (sensor_valid),
        .sensor_ready       (sensor_ready),
        .sensor_channel     (sensor_channel),
        .sensor_sample      (sensor_sample),
        .result_valid       (result_valid),
        .result_ready       (result_ready),
        .chosen_road        (chosen_road),
        .lamp_pattern       (lamp_pattern),
        .road_one_balance   (road_one_balance),
        .road_two_balance   (road_two_balance),
        .road_three_balance (road_three_balance),
        .road_four_balance  (road_four_balance)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic readout_t tally_sample(channel_t ch, sample_t smp);
        balance_t bal [ROAD_COUNT];
        int       best;
        readout_t r;
        if (smp < thresholds[ch])
        begin
            if (!occupied[ch])
            begin
                occupied[ch] = 1'b1;
                passes[ch]   = passes[ch] + 1'b1;
            end
        end
        else if (smp > thresholds[ch])
        begin
            occupied[ch] = 1'b0;
        end
        best = 0;
        for (int k = 0; k < ROAD_COUNT; k++)
        begin
            bal[k] = balance_t'(passes[ADDEND_CH[k]] - passes[SUBTRAHEND_CH[k]]);
            if (bal[k] > bal[best])
                best = k;
        end
        r.road  = road_t'(best);
        r.lamp  = LAMP_OF_ROAD[best];
        r.one   = bal[0];
        r.two   = bal[1];
        r.three = bal[2];
        r.four  = bal[3];
        return r;
    endfunction

    function automatic sample_t pick_sample(channel_t ch);
        int th;
        int sel;
        th  = int'(thresholds[ch]);
        sel = $urandom_range(0, 9);
        if (sel < 4 && th > 0)
            return sample_t'($urandom_range(0, th - 1));
        if (sel < 8 && th < SAMPLE_MAX)
            return sample_t'($urandom_range(th + 1, SAMPLE_MAX));
        if (sel == 8)
            return sample_t'(th);
        return sample_t'($urandom_range(0, SAMPLE_MAX));
    endfunction

    task automatic log_miss(string what);
        if (miss_count < MISS_PRINT_CAP)
            $display("mismatch at %0t: %s", $time, what);
        miss_count++;
    endtask

    task automatic send_beat(channel_t ch, sample_t smp, logic typed, readout_t want);
        int       gap;
        readout_t pred;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            sensor_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sensor_valid   <= 1'b1;
        sensor_channel <= ch;
        sensor_sample  <= smp;
        do @(posedge clk); while (!sensor_ready);
        pred = tally_sample(ch, smp);
        pending_readouts.push_back(typed ? want : pred);
    endtask

    task automatic drain();
        sensor_valid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(cfg_index_t idx, cfg_data_t val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx < SENSOR_COUNT)
            thresholds[idx[CHANNEL_BITS-1:0]] = thresh_t'(val);
    endtask

    task automatic run_random(int beats);
        channel_t ch;
        channel_t favored;
        favored = '0;
        for (int n = 0; n < beats; n++)
        begin
            if (n % CHUNK_BEATS == 0)
            begin
                gap_max   = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
                stall_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
                favored   = channel_t'($urandom_range(0, SENSOR_COUNT - 1));
            end
            if ($urandom_range(0, 1) == 0)
                ch = favored;
            else
                ch = channel_t'($urandom_range(0, SENSOR_COUNT - 1));
            send_beat(ch, pick_sample(ch), 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        readout_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_readouts.size() == 0)
            begin
                log_miss("result beat with no sample pending");
            end
            else
            begin
                want = pending_readouts.pop_front();
                if (chosen_road !== want.road)
                    log_miss($sformatf("chosen_road %0d, want %0d", chosen_road, want.road));
                if (lamp_pattern !== want.lamp)
                    log_miss($sformatf("lamp_pattern %h, want %h", lamp_pattern, want.lamp));
                if (road_one_balance !== want.one)
                    log_miss($sformatf("road_one_balance %0d, want %0d",
                                       road_one_balance, want.one));
                if (road_two_balance !== want.two)
                    log_miss($sformatf("road_two_balance %0d, want %0d",
                                       road_two_balance, want.two));
                if (road_three_balance !== want.three)
                    log_miss($sformatf("road_three_balance %0d, want %0d",
                                       road_three_balance, want.three));
                if (road_four_balance !== want.four)
                    log_miss($sformatf("road_four_balance %0d, want %0d",
                                       road_four_balance, want.four));
            end
            ready_hold = $urandom_range(0, stall_max);
            if (ready_hold > 0)
            begin
                result_ready <= 1'b0;
                ready_hold--;
            end
        end
        else if (!result_ready)
        begin
            if (ready_hold == 0)
                result_ready <= 1'b1;
            else
                ready_hold--;
        end
    end

    initial
    begin : stimulus
        step_row_t directed_rows [$];
        for (int k = 0; k < SENSOR_COUNT; k++)
        begin
            thresholds[k] = THRESH_DEFAULT[k];
            occupied[k]   = 1'b0;
            passes[k]     = '0;
        end
        directed_rows = '{
            '{3'd0, 10'd1023, 1'b1, '{ROAD_ONE,   8'hA9, 16'h0000, 16'h0000, 16'h0000, 16'h0000}},
            '{3'd0, 10'd0,    1'b1, '{ROAD_TWO,   8'hA6, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000}},
            '{3'd0, 10'd0,    1'b1, '{ROAD_TWO,   8'hA6, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000}},
            '{3'd0, 10'd400,  1'b1, '{ROAD_TWO,   8'hA6, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000}},
            '{3'd0, 10'd401,  1'b1, '{ROAD_TWO,   8'hA6, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000}},
            '{3'd7, 10'd162,  1'b1, '{ROAD_THREE, 8'h9A, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000}},
            '{3'd6, 10'd0,    1'b1, '{ROAD_THREE, 8'h9A, 16'h0000, 16'h0000, 16'h0001, 16'h0000}},
            '{3'd1, 10'd612,  1'b1, '{ROAD_THREE, 8'h9A, 16'h0000, 16'h0000, 16'h0001, 16'h0001}},
            '{3'd5, 10'd203,  1'b1, '{ROAD_FOUR,  8'h6A, 16'h0000, 16'h0000, 16'h0000, 16'h0001}},
            '{3'd2, 10'd479,  1'b1, '{ROAD_TWO,   8'hA6, 16'h0000, 16'h0001, 16'h0000, 16'h0001}},
            '{3'd3, 10'd561,  1'b1, '{ROAD_FOUR,  8'h6A, 16'h0000, 16'h0000, 16'h0000, 16'h0001}},
            '{3'd4, 10'd571,  1'b1, '{ROAD_ONE,   8'hA9, 16'h0000, 16'h0000, 16'h0000, 16'h0000}},
            '{3'd6, 10'd1023, 1'b0, '0},
            '{3'd6, 10'd522,  1'b0, '0},
            '{3'd7, 10'd1023, 1'b0, '0},
            '{3'd7, 10'd0,    1'b0, '0},
            '{3'd3, 10'd562,  1'b0, '0},
            '{3'd5, 10'd1023, 1'b0, '0},
            '{3'd5, 10'd0,    1'b0, '0},
            '{3'd1, 10'd1023, 1'b0, '0},
            '{3'd4, 10'd1023, 1'b0, '0},
            '{3'd2, 10'd0,    1'b0, '0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_beat(directed_rows[k].ch, directed_rows[k].smp,
                      directed_rows[k].typed, directed_rows[k].want);

        // toggle one channel in and out at full rate
        write_threshold(cfg_index_t'(THRESH_REG_BASE + WRAP_CHANNEL), cfg_data_t'(512));
        gap_max   = 0;
        stall_max = 0;
        for (int k = 0; k < WRAP_PASSES; k++)
        begin
            send_beat(WRAP_CHANNEL, sample_t'(0), 1'b0, '0);
            send_beat(WRAP_CHANNEL, sample_t'(SAMPLE_MAX), 1'b0, '0);
        end

        run_random(RANDOM_PHASE_BEATS);

        for (int k = 0; k < SENSOR_COUNT; k++)
            write_threshold(cfg_index_t'(THRESH_REG_BASE + k),
                            cfg_data_t'($urandom_range(0, SAMPLE_MAX)));
        run_random(RANDOM_PHASE_BEATS);

        for (int k = 0; k < SENSOR_COUNT; k++)
            write_threshold(cfg_index_t'(THRESH_REG_BASE + k),
                            (k % 2 == 0) ? CFG_DATA_MIN : CFG_DATA_MAX);
        run_random(RANDOM_PHASE_BEATS);

        // hold extremes; these writes must not land anywhere
        write_threshold(UNMAPPED_REG_FIRST, CFG_DATA_MAX);
        write_threshold(UNMAPPED_REG_LAST, CFG_DATA_MIN);
        run_random(RANDOM_PHASE_BEATS / 2);

        for (int k = 0; k < SENSOR_COUNT; k++)
            write_threshold(cfg_index_t'(THRESH_REG_BASE + k),
                            (k % 2 == 1) ? cfg_data_t'(THRESH_DEFAULT[k])
                                         : cfg_data_t'($urandom_range(0, SAMPLE_MAX)));
        run_random(RANDOM_PHASE_BEATS / 2);
        drain();
        run_random(RANDOM_PHASE_BEATS - RANDOM_PHASE_BEATS / 2);

        drain();
        repeat (8) @(posedge clk);
        if (miss_count == 0)
            $display("PASS traffic_count_road_selector");
        else
            $display("FAIL traffic_count_road_selector");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL traffic_count_road_selector");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tcrs_pkg.sv
hdl/tcrs_front.sv
hdl/tcrs_queue.sv
hdl/tcrs_back.sv
hdl/traffic_count_road_selector.sv
dv/traffic_count_road_selector_tb.sv
